/* sv/hsv_pixel_adjust_assert.svh */
// Assertion macros for the pixel adjust RTL.
`ifndef HSV_PIXEL_ADJUST_ASSERT_SVH
`define HSV_PIXEL_ADJUST_ASSERT_SVH
// a implies b at the same edge
`define HPA_ASSERT_IMP(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("%m: implication failed");
// a implies b at the next edge
`define HPA_ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("%m: next-cycle check failed");
`endif

/* sv/hpa_pkg.sv */
// Package with constants and types of the pixel adjust block.
`timescale 1ns / 1ps
package hpa_pkg;
	localparam int FRAC = 12;
	localparam int ONE = 1 << FRAC;
	localparam int FW = FRAC + 1;
	localparam int HUE_FULL = 23040;
	localparam int HUE_SECTOR = 3840;
	localparam int GAIN_FRAC = 12;
	localparam int DIV_N = 20;
	localparam int DIV_D = 9;
	localparam int DIV_Q = 20;
	localparam logic [1:0] IDX_HUE = 2'd0;
	localparam logic [1:0] IDX_SAT = 2'd1;
	localparam logic [1:0] IDX_VAL = 2'd2;
	localparam logic [1:0] MAX_R = 2'd0;
	localparam logic [1:0] MAX_G = 2'd1;
	localparam logic [1:0] MAX_B = 2'd2;

	typedef struct packed {
		logic [DIV_N-1:0] rem;
		logic [DIV_Q-1:0] quo;
		logic [DIV_D-1:0] den;
	} div_t;
endpackage

/* sv/hpa_div.sv */
// Pipelined restoring divider: one quotient bit per stage.
`timescale 1ns / 1ps
module hpa_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [hpa_pkg::DIV_N-1:0]   num,
	input  logic [hpa_pkg::DIV_D-1:0]   den,
	output logic [hpa_pkg::DIV_Q-1:0]   quo
);
	localparam int N = hpa_pkg::DIV_N;
	hpa_pkg::div_t init;
	hpa_pkg::div_t src [N];
	hpa_pkg::div_t nx [N];
	hpa_pkg::div_t st_q [N];

	assign init = '{rem: '0, quo: num, den: den};

	always_comb begin
		src[0] = init;
		for (int i = 1; i < N; i++) src[i] = st_q[i-1];
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			logic [hpa_pkg::DIV_D:0] tr;
			logic [N-1:0] sh;
			sh = {src[i].rem[N-2:0], src[i].quo[N-1]};
			nx[i] = src[i];
			nx[i].quo = {src[i].quo[N-2:0], 1'b0};
			tr = {1'b0, src[i].den};
			if (sh >= N'(tr)) begin
				nx[i].rem = sh - N'(tr);
				nx[i].quo[0] = 1'b1;
			end else begin
				nx[i].rem = sh;
			end
		end
	end

	// one register per stage; data needs no reset
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) st_q[i] <= nx[i];
		end
	end

	assign quo = st_q[N-1].quo;
endmodule

/* sv/hsv_pixel_adjust.sv */
// Top level: RGB to HSV, hue/saturation/value adjust, back to RGB.
// channel | dir | content
// s_axis  | in  | tdata: red, green, blue; tlast: last
// m_axis  | out | tdata: red, green, blue; tlast: last
// cfg     | in  | we, idx, data (hue shift, sat gain, value gain)
// One pixel per cycle while the output is not stalled; 27 register stages (two
// 20-stage dividers dominate).
// Pipeline advances whenever the output register is empty or taken.
// Stalls freeze all stages; nothing is lost or repeated.
// arst_n clears valid bits and resets gains to unity, hue shift to zero.
`timescale 1ns / 1ps
module hsv_pixel_adjust (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // red, green, blue
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // red, green, blue
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data
);
	localparam int F = hpa_pkg::FRAC;
	localparam int FW = hpa_pkg::FW;
	localparam int L = hpa_pkg::DIV_N;
	localparam int NV = L + 7;

	logic signed [15:0] hue_q, sat_q, val_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q <= '0;
			sat_q <= 16'sd4096;
			val_q <= 16'sd4096;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				hpa_pkg::IDX_HUE: hue_q <= cfg_data;
				hpa_pkg::IDX_SAT: sat_q <= cfg_data;
				hpa_pkg::IDX_VAL: val_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic [NV-1:0] vld_q;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[NV-2:0], s_axis_tvalid};
	end

	// stage 1: max/min, numerators
	logic [7:0] r, g, b, mx, mn;
	logic [1:0] which;
	assign r = s_axis_tdata[7:0];
	assign g = s_axis_tdata[15:8];
	assign b = s_axis_tdata[23:16];
	always_comb begin
		mx = r; which = hpa_pkg::MAX_R;
		if (g > mx) begin mx = g; which = hpa_pkg::MAX_G; end
		if (b > mx) begin mx = b; which = hpa_pkg::MAX_B; end
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
	end
	logic [7:0] mx_s1, dl_s1, hn_s1;
	logic [1:0] wh_s1;
	logic neg_s1, last_s1;
	logic signed [8:0] num;
	always_comb begin
		case (which)
			hpa_pkg::MAX_R: num = $signed({1'b0, g}) - $signed({1'b0, b});
			hpa_pkg::MAX_G: num = $signed({1'b0, b}) - $signed({1'b0, r});
			default:        num = $signed({1'b0, r}) - $signed({1'b0, g});
		endcase
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= mx;
			dl_s1 <= mx - mn;
			wh_s1 <= which;
			neg_s1 <= num[8];
			hn_s1 <= num[8] ? 8'(-num) : num[7:0];
			last_s1 <= s_axis_tlast;
		end
	end

	// dividers: hue part and saturation
	logic [L-1:0] hq, sq;
	hpa_div u_hdiv (.clk, .en,
		.num(L'(hn_s1) * L'(hpa_pkg::HUE_SECTOR)), .den({1'b0, dl_s1}), .quo(hq));
	hpa_div u_sdiv (.clk, .en,
		.num(L'(dl_s1) << F), .den({1'b0, mx_s1}), .quo(sq));

	// delay side data through L registers, alongside the dividers
	logic [7:0] mx_d [L];
	logic [7:0] dl_d [L];
	logic [1:0] wh_d [L];
	logic neg_d [L];
	logic last_d [L];
	always_ff @(posedge clk) begin
		if (en) begin
			mx_d[0] <= mx_s1; dl_d[0] <= dl_s1; wh_d[0] <= wh_s1;
			neg_d[0] <= neg_s1; last_d[0] <= last_s1;
			for (int i = 1; i < L; i++) begin
				mx_d[i] <= mx_d[i-1]; dl_d[i] <= dl_d[i-1]; wh_d[i] <= wh_d[i-1];
				neg_d[i] <= neg_d[i-1]; last_d[i] <= last_d[i-1];
			end
		end
	end

	// stage A: hue, raw v, s
	logic signed [17:0] hraw;
	logic [FW-1:0] vraw, sraw;
	always_comb begin
		logic signed [17:0] p;
		logic [12:0] n16;
		p = neg_d[L-1] ? -$signed(18'(hq)) : $signed(18'(hq));
		if (dl_d[L-1] == 8'd0) hraw = '0;
		else begin
			case (wh_d[L-1])
				hpa_pkg::MAX_R: hraw = (p < 0) ? p + 18'sd23040 : p;
				hpa_pkg::MAX_G: hraw = 18'sd7680 + p;
				default:        hraw = 18'sd15360 + p;
			endcase
		end
		// mx*ONE/255 = 16*mx + floor(16*mx/255); the floor is exact for 16*mx < 4096
		n16 = {1'b0, mx_d[L-1], 4'b0};
		vraw = FW'(n16) + FW'((n16 + (n16 >> 8) + 13'd1) >> 8);
		sraw = (mx_d[L-1] == 8'd0) ? '0 : FW'(sq);
	end
	logic signed [17:0] h_a;
	logic [FW-1:0] s_a, v_a;
	logic last_a;
	always_ff @(posedge clk) begin
		if (en) begin
			h_a <= hraw + 18'(hue_q);
			s_a <= sraw; v_a <= vraw; last_a <= last_d[L-1];
		end
	end

	// stage B: wrap hue, apply gains
	function automatic logic [FW-1:0] gain(input logic [FW-1:0] f,
			input logic signed [15:0] gn);
		logic [FW+15:0] p;
		p = (FW+16)'(f) * (FW+16)'(gn[14:0]);
		p = p >> hpa_pkg::GAIN_FRAC;
		if (gn[15] || gn == 16'sd0 || f == '0) return '0;
		if (p > (FW+16)'(hpa_pkg::ONE)) return FW'(hpa_pkg::ONE);
		return FW'(p);
	endfunction
	logic signed [17:0] hw;
	always_comb begin
		hw = h_a;
		if (hw < 0) hw = hw + 18'sd23040;
		if (hw >= 18'sd23040) hw = hw - 18'sd23040;
		if (hw < 0) hw = '0;
		if (hw > 18'sd23039) hw = 18'sd23039;
	end
	logic [14:0] h_b;
	logic [FW-1:0] s_b, v_b;
	logic last_b;
	always_ff @(posedge clk) begin
		if (en) begin
			h_b <= hw[14:0]; s_b <= gain(s_a, sat_q); v_b <= gain(v_a, val_q);
			last_b <= last_a;
		end
	end

	// stage C: chroma, sector, distance
	logic [2:0] sec;
	logic [12:0] t;
	always_comb begin
		sec = (h_b >= 15'd19200) ? 3'd5 : (h_b >= 15'd15360) ? 3'd4 :
			(h_b >= 15'd11520) ? 3'd3 : (h_b >= 15'd7680) ? 3'd2 :
			(h_b >= 15'd3840) ? 3'd1 : 3'd0;
		t = (h_b >= 15'd15360) ? 13'(h_b - 15'd15360) :
			(h_b >= 15'd7680) ? 13'(h_b - 15'd7680) : 13'(h_b);
	end
	logic [FW-1:0] c_c, v_c;
	logic [11:0] w_c;
	logic [2:0] sec_c;
	logic last_c;
	always_ff @(posedge clk) begin
		if (en) begin
			c_c <= FW'(((2*FW)'(v_b) * (2*FW)'(s_b)) >> F);
			v_c <= v_b;
			w_c <= (t >= 13'd3840) ? 12'(13'd7680 - t) : t[11:0];
			sec_c <= sec; last_c <= last_b;
		end
	end

	// stage D: x = c*w/3840 via multiply then reciprocal
	logic [FW+11:0] cw_d;
	logic [FW-1:0] c_dd, v_dd;
	logic [2:0] sec_d;
	logic last_dd;
	always_ff @(posedge clk) begin
		if (en) begin
			cw_d <= (FW+12)'(c_c) * (FW+12)'(w_c);
			c_dd <= c_c; v_dd <= v_c; sec_d <= sec_c; last_dd <= last_c;
		end
	end
	// divide by 3840 = 256*15; /15 via reciprocal with one correction
	logic [FW+3:0] q256;
	logic [FW-1:0] xq;
	always_comb begin
		logic [2*FW+7:0] pr;
		logic [FW+3:0] qq;
		q256 = cw_d[FW+11:8];
		pr = (2*FW+8)'(q256) * (2*FW+8)'(18'd69906);
		qq = (FW+4)'(pr >> 20);
		if ((FW+4)'(q256 - qq * 4'd15) >= (FW+4)'(15)) qq = qq + 1'b1;
		xq = FW'(qq);
	end
	logic [FW-1:0] c_e, x_e, m_e;
	logic [2:0] sec_e;
	logic last_e;
	always_ff @(posedge clk) begin
		if (en) begin
			c_e <= c_dd; x_e <= xq; m_e <= v_dd - c_dd; sec_e <= sec_d;
			last_e <= last_dd;
		end
	end

	function automatic logic [7:0] chan(input logic [FW-1:0] f);
		logic [FW+8:0] p;
		p = ((FW+9)'(f) * (FW+9)'(255)) >> F;
		return (p > (FW+9)'(255)) ? 8'd255 : p[7:0];
	endfunction
	logic [FW-1:0] r1, g1, b1;
	always_comb begin
		case (sec_e)
			3'd0: begin r1 = c_e; g1 = x_e; b1 = '0; end
			3'd1: begin r1 = x_e; g1 = c_e; b1 = '0; end
			3'd2: begin r1 = '0; g1 = c_e; b1 = x_e; end
			3'd3: begin r1 = '0; g1 = x_e; b1 = c_e; end
			3'd4: begin r1 = x_e; g1 = '0; b1 = c_e; end
			default: begin r1 = c_e; g1 = '0; b1 = x_e; end
		endcase
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {chan(b1 + m_e), chan(g1 + m_e), chan(r1 + m_e)};
			m_axis_tlast <= last_e;
		end
	end
	assign m_axis_tvalid = vld_q[NV-1];

`include "hsv_pixel_adjust_assert.svh"
	`HPA_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`HPA_ASSERT_IMP(a_rdy, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
	`HPA_ASSERT_NEXT(a_adv, s_axis_tready && s_axis_tvalid, vld_q[0])
endmodule
